// File: rtl/core/urbfc_pkg.sv
package urbfc_pkg;

  // Ring depth used when the top level is not overridden
  localparam int unsigned DEFAULT_RING_DEPTH = 256;

  // Register reset values
  localparam logic [7:0] STOP_LEVEL_RST   = 8'd192;
  localparam logic [7:0] RESUME_LEVEL_RST = 8'd64;

  // Event codes on the input channel
  typedef enum logic [2:0] {
    KIND_PUT   = 3'd0,
    KIND_READ  = 3'd1,
    KIND_TXRDY = 3'd2,
    KIND_RECV  = 3'd3,
    KIND_BREAK = 3'd4
  } kind_e;

  // Where the delivered byte goes
  typedef enum logic [1:0] {
    OKIND_NONE = 2'd0,
    OKIND_HOST = 2'd1,
    OKIND_TX   = 2'd2
  } okind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_RX_EMPTY   = 2'd1,
    STAT_TX_FULL    = 2'd2,
    STAT_RX_OVERRUN = 2'd3
  } status_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_STOP_LEVEL   = 1'b0,
    CFG_RESUME_LEVEL = 1'b1
  } cfg_idx_e;

  // Sequencer states
  typedef enum logic [0:0] {
    FSM_IDLE  = 1'b0,
    FSM_FETCH = 1'b1
  } fsm_e;

  // Per-event command to one ring
  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } ring_ctrl_t;

  // One result word
  typedef struct packed {
    logic [7:0] data_out;
    okind_e     out_kind;
    status_e    status;
    logic       flow_stop;
    logic       tx_irq_on;
    logic [7:0] rx_level;
    logic [7:0] tx_level;
  } res_t;

endpackage

// File: rtl/core/uart_ring_buffers_flow_control_unit.sv
// Channel   Direction  Handshake                Words
// ev        in         in_valid_i / in_ready_o  kind_i, data_in_i
// res       out        out_valid_o / out_ready_i data_out_o .. tx_level_o
// cfg       in         cfg_we_i (no wait)       cfg_index_i, cfg_wdata_i
//
// An event that moves no stored byte loads the result register directly; a
// host read or a transmitter-ready event that pops a byte waits in FETCH for
// the registered read of the ring memory. One event is in flight at a time.
// Reset clears pointers, flow pin, transmit interest and the result valid flag;
// ring contents stay undefined until written. A stalled result blocks new
// events only when the output register is full and not being taken.
module uart_ring_buffers_flow_control_unit #(
  parameter int unsigned RING_DEPTH = urbfc_pkg::DEFAULT_RING_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // event channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [2:0] kind_i,
  input  logic [7:0] data_in_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] data_out_o,
  output logic [1:0] out_kind_o,
  output logic [1:0] status_o,
  output logic       flow_stop_o,
  output logic       tx_irq_on_o,
  output logic [7:0] rx_level_o,
  output logic [7:0] tx_level_o,
  // configuration
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [7:0] cfg_wdata_i
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned LW = (AW > 8) ? AW : 8;

  logic [7:0] stop_level_q, resume_level_q;
  logic       flow_q, flow_d;
  logic       armed_q, armed_d;
  urbfc_pkg::fsm_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  urbfc_pkg::res_t out_q, pend_q, res_now, res_fetch;

  urbfc_pkg::ring_ctrl_t tx_ctrl, rx_ctrl;
  logic [7:0]    tx_rdata, rx_rdata;
  logic          tx_empty, tx_full, rx_empty, rx_full;
  logic [AW-1:0] tx_lvl_nxt, rx_lvl_nxt;
  logic [LW-1:0] tx_lvl_w, rx_lvl_w;

  logic acc, out_free, need_mem, load_direct, load_fetch;
  urbfc_pkg::kind_e kind;

  assign acc      = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign kind     = urbfc_pkg::kind_e'(kind_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_level_q   <= urbfc_pkg::STOP_LEVEL_RST;
      resume_level_q <= urbfc_pkg::RESUME_LEVEL_RST;
    end else if (cfg_we_i) begin
      case (urbfc_pkg::cfg_idx_e'(cfg_index_i))
        urbfc_pkg::CFG_STOP_LEVEL:   stop_level_q   <= cfg_wdata_i;
        urbfc_pkg::CFG_RESUME_LEVEL: resume_level_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Rings
  urbfc_ring #(.RING_DEPTH(RING_DEPTH)) u_tx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (tx_ctrl),
    .wdata_i     (data_in_i),
    .rdata_o     (tx_rdata),
    .empty_o     (tx_empty),
    .full_o      (tx_full),
    .level_nxt_o (tx_lvl_nxt)
  );

  urbfc_ring #(.RING_DEPTH(RING_DEPTH)) u_rx_ring (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (rx_ctrl),
    .wdata_i     (data_in_i),
    .rdata_o     (rx_rdata),
    .empty_o     (rx_empty),
    .full_o      (rx_full),
    .level_nxt_o (rx_lvl_nxt)
  );

  assign tx_lvl_w = LW'(tx_lvl_nxt);
  assign rx_lvl_w = LW'(rx_lvl_nxt);

  // Event decode: ring commands, flags and the result without its byte
  always_comb begin
    tx_ctrl  = '0;
    rx_ctrl  = '0;
    flow_d   = flow_q;
    armed_d  = armed_q;
    need_mem = 1'b0;
    res_now  = '0;
    res_now.out_kind = urbfc_pkg::OKIND_NONE;
    res_now.status   = urbfc_pkg::STAT_OK;
    case (kind)
      urbfc_pkg::KIND_PUT: begin
        if (tx_full) res_now.status = urbfc_pkg::STAT_TX_FULL;
        else         tx_ctrl.push   = acc;
        armed_d = 1'b1;
      end
      urbfc_pkg::KIND_READ: begin
        if (rx_empty) begin
          res_now.status = urbfc_pkg::STAT_RX_EMPTY;
        end else begin
          rx_ctrl.pop      = acc;
          need_mem         = 1'b1;
          res_now.out_kind = urbfc_pkg::OKIND_HOST;
          if (rx_lvl_w < LW'(resume_level_q)) flow_d = 1'b0;
        end
      end
      urbfc_pkg::KIND_TXRDY: begin
        if (armed_q) begin
          if (tx_empty) begin
            armed_d = 1'b0;
          end else begin
            tx_ctrl.pop      = acc;
            need_mem         = 1'b1;
            res_now.out_kind = urbfc_pkg::OKIND_TX;
          end
        end
      end
      urbfc_pkg::KIND_RECV: begin
        if (rx_full) res_now.status = urbfc_pkg::STAT_RX_OVERRUN;
        else         rx_ctrl.push   = acc;
        if (rx_lvl_w > LW'(stop_level_q)) flow_d = 1'b1;
      end
      urbfc_pkg::KIND_BREAK: begin
        rx_ctrl.clear = acc;
        flow_d        = 1'b0;
      end
      default: ;
    endcase
    res_now.flow_stop = flow_d;
    res_now.tx_irq_on = armed_d;
    res_now.rx_level  = rx_lvl_w[7:0];
    res_now.tx_level  = tx_lvl_w[7:0];
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      urbfc_pkg::FSM_IDLE:  if (acc && need_mem) state_d = urbfc_pkg::FSM_FETCH;
      urbfc_pkg::FSM_FETCH: if (out_free)        state_d = urbfc_pkg::FSM_IDLE;
      default:              state_d = urbfc_pkg::FSM_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    load_fetch = 1'b0;
    case (state_q)
      urbfc_pkg::FSM_IDLE:  in_ready_o = out_free;
      urbfc_pkg::FSM_FETCH: load_fetch = out_free;
      default: ;
    endcase
  end

  assign load_direct = acc && !need_mem;

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_direct || load_fetch) out_valid_d = 1'b1;
    else if (out_ready_i)          out_valid_d = 1'b0;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= urbfc_pkg::FSM_IDLE;
      flow_q      <= 1'b0;
      armed_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (acc) begin
        flow_q  <= flow_d;
        armed_q <= armed_d;
      end
    end
  end

  // Fetched word: pending meta plus the byte from the ring read
  always_comb begin
    res_fetch          = pend_q;
    res_fetch.data_out = (pend_q.out_kind == urbfc_pkg::OKIND_HOST) ? rx_rdata : tx_rdata;
  end

  // Result words: pending meta while the ring byte is fetched
  always_ff @(posedge clk_i) begin
    if (acc) pend_q <= res_now;
    if (load_direct) begin
      out_q <= res_now;
    end else if (load_fetch) begin
      out_q <= res_fetch;
    end
  end

  assign out_valid_o = out_valid_q;
  assign data_out_o  = out_q.data_out;
  assign out_kind_o  = out_q.out_kind;
  assign status_o    = out_q.status;
  assign flow_stop_o = out_q.flow_stop;
  assign tx_irq_on_o = out_q.tx_irq_on;
  assign rx_level_o  = out_q.rx_level;
  assign tx_level_o  = out_q.tx_level;

  // A delivered byte always comes with an ok status
  a_deliver_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_kind_o != urbfc_pkg::OKIND_NONE) |-> status_o == urbfc_pkg::STAT_OK)
    else $error("byte delivered with error status");

  // Flow stop only rises on a received byte
  a_flow_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flow_q) |-> $past(acc && (kind == urbfc_pkg::KIND_RECV)))
    else $error("flow stop set outside a receive");

  // No new event while a ring byte is being fetched
  a_fetch_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && need_mem |=> !in_ready_o)
    else $error("event taken during ring fetch");

endmodule

// File: rtl/core/urbfc_ring.sv
module urbfc_ring #(
  parameter int unsigned RING_DEPTH = urbfc_pkg::DEFAULT_RING_DEPTH,
  localparam int unsigned AW = $clog2(RING_DEPTH)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  urbfc_pkg::ring_ctrl_t ctrl_i,
  input  logic [7:0]           wdata_i,
  output logic [7:0]           rdata_o,
  output logic                 empty_o,
  output logic                 full_o,
  output logic [AW-1:0]        level_nxt_o
);

  logic [7:0]    mem_q [RING_DEPTH];
  logic [7:0]    rdata_q;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] level_cur;

  function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
    return (p == AW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ring_level(input logic [AW-1:0] h,
                                                input logic [AW-1:0] t);
    logic [AW:0] wrap;
    wrap = {1'b0, h} + (AW+1)'(RING_DEPTH) - {1'b0, t};
    return (h >= t) ? (h - t) : wrap[AW-1:0];
  endfunction

  // Pointer update; clear wins over everything
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (ctrl_i.clear) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (ctrl_i.push) head_d = ptr_next(head_q);
      if (ctrl_i.pop)  tail_d = ptr_next(tail_q);
    end
  end

  assign level_cur   = ring_level(head_q, tail_q);
  assign level_nxt_o = ring_level(head_d, tail_d);
  assign empty_o     = (head_q == tail_q);
  assign full_o      = (level_cur >= AW'(RING_DEPTH - 1));
  assign rdata_o     = rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Byte store: one write at head, one registered read at tail.
  // A single event never pushes and pops the same ring, so no bypass is needed.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) mem_q[head_q] <= wdata_i;
    if (ctrl_i.pop)  rdata_q <= mem_q[tail_q];
  end

endmodule
